// File: design/modular_exponentiation_assert.svh
// assertion macros for the modular exponentiation control module
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// property checked every clock edge outside reset
`define MODEXP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent on the following clock edge
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/modexp_pkg.sv
// types, constants and codes for the modular exponentiation block
`timescale 1ns / 1ps

package modexp_pkg;

   localparam int FIELD_W   = 32;
   localparam int RESULT_W  = 64;
   localparam int HALF_W    = 32;
   localparam int KIND_W    = 2;
   localparam int WIDTH_DEF = 32;

   localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MOD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INV   = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] exponent;
      logic [FIELD_W-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] result;
      logic                error;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_idx;
      logic       use_acc;
      logic       reduce;
      logic       write;
      logic       write_acc;
      logic       shift;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic plain;
      logic exp_zero;
      logic exp_lsb;
      logic exp_rest_zero;
   } status_type;

endpackage

// File: design/modexp_datapath.sv
// operand registers, shared multiplier and bit-serial remainder unit
`timescale 1ns / 1ps

module modexp_datapath #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
   input  logic                   clock,
   input  modexp_pkg::req_type    req_data,
   input  modexp_pkg::cmd_type    cmd,
   output modexp_pkg::status_type status,
   output modexp_pkg::rsp_type    rsp_data
);
   import modexp_pkg::*;

   logic [KIND_W-1:0]   kind_ff;
   logic [RESULT_W-1:0] acc_ff;
   logic [RESULT_W-1:0] base_ff;
   logic [RESULT_W-1:0] prod_ff;
   logic [RESULT_W-1:0] mul_ff;
   logic [WIDTH-1:0]    exp_ff;
   logic [WIDTH-1:0]    mod_ff;
   logic [WIDTH-1:0]    rem_ff;
   rsp_type             rsp_ff;

   logic [WIDTH-1:0]    load_mod;
   logic [WIDTH-1:0]    load_exp;
   logic [RESULT_W-1:0] a_op;
   logic [HALF_W-1:0]   mul_x;
   logic [HALF_W-1:0]   mul_y;
   logic [RESULT_W-1:0] mul_prod;
   logic [WIDTH:0]      trial;
   logic [WIDTH:0]      diff;
   logic [RESULT_W-1:0] wb_value;
   logic                modular;

   assign load_mod = req_data.modulus[WIDTH-1:0];

   always_comb begin
      if (req_data.kind == KIND_INV) begin
         load_exp = (load_mod >= WIDTH'(2)) ? (load_mod - WIDTH'(2)) : '0;
      end else begin
         load_exp = req_data.exponent[WIDTH-1:0];
      end
   end

   assign a_op = cmd.use_acc ? acc_ff : base_ff;

   always_comb begin
      case (cmd.mul_idx)
         2'd1: begin
            mul_x = a_op[RESULT_W-1:HALF_W];
            mul_y = base_ff[HALF_W-1:0];
         end
         2'd2: begin
            mul_x = a_op[HALF_W-1:0];
            mul_y = base_ff[RESULT_W-1:HALF_W];
         end
         default: begin
            mul_x = a_op[HALF_W-1:0];
            mul_y = base_ff[HALF_W-1:0];
         end
      endcase
   end

   assign mul_prod = mul_x * mul_y;

   // restoring remainder step
   assign trial    = {rem_ff, prod_ff[2*WIDTH-1]};
   assign diff     = trial - {1'b0, mod_ff};

   assign modular  = (kind_ff == KIND_MOD) || (kind_ff == KIND_INV);
   assign wb_value = (kind_ff == KIND_PLAIN) ? prod_ff : RESULT_W'(rem_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_data.kind;
         acc_ff  <= RESULT_W'(1);
         base_ff <= RESULT_W'(req_data.base[WIDTH-1:0]);
         mod_ff  <= load_mod;
         exp_ff  <= load_exp;
      end
      if (cmd.mul_en) begin
         mul_ff <= mul_prod;
         case (cmd.mul_idx)
            2'd0: ;
            2'd1: prod_ff <= mul_ff;
            default: begin
               prod_ff[RESULT_W-1:HALF_W] <= prod_ff[RESULT_W-1:HALF_W] + mul_ff[HALF_W-1:0];
            end
         endcase
         if (cmd.mul_idx == 2'd3) begin
            rem_ff <= '0;
         end
      end
      if (cmd.reduce) begin
         prod_ff <= prod_ff << 1;
         rem_ff  <= diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
      end
      if (cmd.write) begin
         if (cmd.write_acc) begin
            acc_ff <= wb_value;
         end else begin
            base_ff <= wb_value;
         end
      end
      if (cmd.shift) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.finish) begin
         rsp_ff.result <= status.bad ? '0 : acc_ff;
         rsp_ff.error  <= status.bad;
      end
   end

   assign status.plain         = (kind_ff == KIND_PLAIN);
   assign status.bad           = !status.plain && (!modular || (mod_ff == '0));
   assign status.exp_zero      = (exp_ff == '0);
   assign status.exp_lsb       = exp_ff[0];
   assign status.exp_rest_zero = (exp_ff[WIDTH-1:1] == '0);

   assign rsp_data = rsp_ff;

endmodule

// File: design/modexp_control.sv
// sequencer for square-and-multiply over the shared datapath
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module modexp_control #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  modexp_pkg::status_type status,
   output modexp_pkg::cmd_type    cmd,
   output logic                   rsp_valid
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(2 * WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BEGIN,
      ST_CHECK,
      ST_MUL,
      ST_RED,
      ST_WRITE,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             acc_op_ff, acc_op_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_op_in    = acc_op_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_BEGIN;
            end
         end
         ST_BEGIN: begin
            state_in = status.bad ? ST_FINISH : ST_CHECK;
         end
         ST_CHECK: begin
            cnt_in    = '0;
            acc_op_in = status.exp_lsb;
            state_in  = status.exp_zero ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = cnt_ff[1:0];
            cmd.use_acc = acc_op_ff;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               state_in = status.plain ? ST_WRITE : ST_RED;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_RED: begin
            cmd.reduce = 1'b1;
            if (cnt_ff == CNT_W'(2 * WIDTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_WRITE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_WRITE: begin
            cmd.write     = 1'b1;
            cmd.write_acc = acc_op_ff;
            if (acc_op_ff) begin
               acc_op_in = 1'b0;
               state_in  = status.exp_rest_zero ? ST_FINISH : ST_MUL;
            end else begin
               cmd.shift = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_FINISH: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         acc_op_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_op_ff    <= acc_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `MODEXP_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff, "result strobe held")
   `MODEXP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer not taken")
   `MODEXP_ASSERT(a_red_modular, (state_ff != ST_RED) || !status.plain, "reduction in plain kind")
   `MODEXP_ASSERT_NEXT(a_finish_valid, state_ff == ST_FINISH, rsp_valid_ff && !busy,
                       "finish without result")

endmodule

// File: design/modular_exponentiation.sv
// top level of the square-and-multiply modular exponentiation block
//
//  channel   ports                      transfer
//  request   start, busy, req_data      start high while busy low
//  response  rsp_valid, rsp_data        every cycle rsp_valid is high
//
// one request at a time; busy stays high from the transfer until the result strobe
// each multiply is built from partial products on one 32x32 multiplier; each modular
// one adds a bit-serial remainder before its result is written back
// steps are one per set exponent bit plus one squaring per bit below the top set bit,
// and each bit up to the top set bit also passes through the check state
// synchronous reset clears the sequencer only; the receiver cannot stall the result
`timescale 1ns / 1ps

module modular_exponentiation #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  modexp_pkg::req_type req_data,
   output logic                rsp_valid,
   output modexp_pkg::rsp_type rsp_data
);
   import modexp_pkg::*;

   cmd_type    cmd;
   status_type status;

   modexp_control #(
      .WIDTH (WIDTH)
   ) u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   modexp_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
